FILE: src/kwsc_pkg.sv
package kwsc_pkg;

  localparam int ALPHA = 26;
  localparam int IDX_W = 5;

  localparam logic [7:0] UPPER_A = 8'd65;
  localparam logic [7:0] LOWER_A = 8'd97;

  localparam logic [1:0] OP_KEY = 2'd0;
  localparam logic [1:0] OP_ENC = 2'd1;
  localparam logic [1:0] OP_DEC = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic rd_en;
    idx_t rd_addr;
    logic wr_en;
    idx_t wr_addr;
    idx_t wr_data;
  } tbl_req_t;

endpackage

FILE: src/kwsc_ram.sv
module kwsc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 26,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/kwsc_tbl.sv
module kwsc_tbl (
  input  logic              clk,
  input  logic              rst_n,
  input  kwsc_pkg::tbl_req_t req,
  output kwsc_pkg::idx_t    rd_data
);

  // An entry that has never been written reads as its own index.
  logic [kwsc_pkg::ALPHA-1:0] vld_r;
  logic [kwsc_pkg::ALPHA-1:0] vld_nxt;
  logic                       rd_vld_r;
  kwsc_pkg::idx_t             rd_addr_r;
  kwsc_pkg::idx_t             ram_q;

  kwsc_ram #(
    .WIDTH(kwsc_pkg::IDX_W),
    .DEPTH(kwsc_pkg::ALPHA)
  ) u_ram (
    .clk    (clk),
    .wr_en  (req.wr_en),
    .wr_addr(req.wr_addr),
    .wr_data(req.wr_data),
    .rd_en  (req.rd_en),
    .rd_addr(req.rd_addr),
    .rd_data(ram_q)
  );

  always_comb begin
    vld_nxt = vld_r;
    if (req.wr_en) begin
      vld_nxt[req.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_vld_r  <= vld_r[req.rd_addr];
      rd_addr_r <= req.rd_addr;
    end
  end

  assign rd_data = rd_vld_r ? ram_q : rd_addr_r;

endmodule

FILE: src/keyword_substitution_cipher_core.sv
// Keyword substitution cipher, one byte per transfer.
// Input channel: in_valid/in_ready carry in_op, in_data_byte and in_key_last.
// Key bytes (op 0) build the substitution table and give no result; the key
// byte with in_key_last set completes the table with the unused letters.
// Encrypt (op 1) and decrypt (op 2) bytes each give one out_byte on the
// out_valid/out_ready channel; op 3 is taken and dropped.
// A cipher byte's read is registered in the read stage, its result in the
// output register. Throughput: one cipher byte per cycle unless the output
// stalls or key bytes hold off input. A key byte that places a new letter
// holds off input in ST_WR1 and ST_WR2, since placing is a read of both
// tables followed by two writes to each. A final key byte holds off input
// while ST_FILL scans all 26 letters one per cycle, placing each unused one
// through ST_WR1 and ST_WR2. The tables live in two 26-entry memories with
// valid bits, so reset makes both tables the identity at once and the block
// is ready in the next cycle. When the receiver stalls, the result waits in
// the output register while one more cipher byte may be taken and held in
// the read stage; after that the input is held off until the output drains.
module keyword_substitution_cipher_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_data_byte,
  input  logic       in_key_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WR1  = 2'd1;
  localparam logic [1:0] ST_WR2  = 2'd2;
  localparam logic [1:0] ST_FILL = 2'd3;

  localparam logic [7:0] UPPER_Z = kwsc_pkg::UPPER_A + 8'(kwsc_pkg::ALPHA - 1);
  localparam logic [7:0] LOWER_Z = kwsc_pkg::LOWER_A + 8'(kwsc_pkg::ALPHA - 1);
  localparam logic [7:0] CASE_OFS = kwsc_pkg::LOWER_A - kwsc_pkg::UPPER_A;
  localparam kwsc_pkg::idx_t ALPHA_N = kwsc_pkg::IDX_W'(kwsc_pkg::ALPHA);

  logic [1:0]                  state_r, state_nxt;
  logic                        pend_r, pend_nxt;
  logic                        pend_dec_r, pend_dec_nxt;
  logic                        pend_hit_r, pend_hit_nxt;
  logic [7:0]                  pend_byte_r, pend_byte_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_byte_r, out_byte_nxt;
  logic                        kl_r, kl_nxt;
  logic [kwsc_pkg::ALPHA-1:0]  used_r, used_nxt;
  kwsc_pkg::idx_t              fill_r, fill_nxt;
  kwsc_pkg::idx_t              scan_r, scan_nxt;
  kwsc_pkg::idx_t              let_r, let_nxt;
  kwsc_pkg::idx_t              pos_r, pos_nxt;
  logic                        last_r, last_nxt;

  kwsc_pkg::tbl_req_t          sub_req, inv_req;
  kwsc_pkg::idx_t              sub_rd, inv_rd;

  logic                        in_fire, adv;
  logic [7:0]                  kc;
  logic                        k_is_let, d_is_let;
  kwsc_pkg::idx_t              k_idx, d_idx, rd_sel;
  logic [kwsc_pkg::ALPHA-1:0]  used_eff;
  kwsc_pkg::idx_t              fill_eff;

  kwsc_tbl u_sub (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (sub_req),
    .rd_data(sub_rd)
  );

  kwsc_tbl u_inv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (inv_req),
    .rd_data(inv_rd)
  );

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && (!pend_r || adv);
  assign in_fire  = in_valid && in_ready;

  assign kc       = (in_data_byte >= kwsc_pkg::LOWER_A && in_data_byte <= LOWER_Z) ?
                    in_data_byte - CASE_OFS : in_data_byte;
  assign k_is_let = (kc >= kwsc_pkg::UPPER_A) && (kc <= UPPER_Z);
  assign k_idx    = kwsc_pkg::IDX_W'(kc - kwsc_pkg::UPPER_A);
  assign d_is_let = (in_data_byte >= kwsc_pkg::UPPER_A) && (in_data_byte <= UPPER_Z);
  assign d_idx    = kwsc_pkg::IDX_W'(in_data_byte - kwsc_pkg::UPPER_A);
  assign used_eff = kl_r ? used_r : '0;
  assign fill_eff = kl_r ? fill_r : '0;
  assign rd_sel   = pend_dec_r ? inv_rd : sub_rd;

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    pend_dec_nxt  = pend_dec_r;
    pend_hit_nxt  = pend_hit_r;
    pend_byte_nxt = pend_byte_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    kl_nxt        = kl_r;
    used_nxt      = used_r;
    fill_nxt      = fill_r;
    scan_nxt      = scan_r;
    let_nxt       = let_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    sub_req       = '0;
    inv_req       = '0;

    if (adv) begin
      out_valid_nxt = pend_r;
      if (pend_r) begin
        if (!pend_hit_r) begin
          out_byte_nxt = pend_byte_r;
        end else if (pend_dec_r) begin
          out_byte_nxt = kwsc_pkg::LOWER_A + {3'b000, rd_sel};
        end else begin
          out_byte_nxt = kwsc_pkg::UPPER_A + {3'b000, rd_sel};
        end
      end
      pend_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            kwsc_pkg::OP_ENC: begin
              sub_req.rd_en   = k_is_let;
              sub_req.rd_addr = k_idx;
              pend_nxt        = 1'b1;
              pend_dec_nxt    = 1'b0;
              pend_hit_nxt    = k_is_let;
              pend_byte_nxt   = in_data_byte;
            end
            kwsc_pkg::OP_DEC: begin
              inv_req.rd_en   = d_is_let;
              inv_req.rd_addr = d_idx;
              pend_nxt        = 1'b1;
              pend_dec_nxt    = 1'b1;
              pend_hit_nxt    = d_is_let;
              pend_byte_nxt   = in_data_byte;
            end
            kwsc_pkg::OP_KEY: begin
              kl_nxt   = 1'b1;
              used_nxt = used_eff;
              fill_nxt = fill_eff;
              last_nxt = in_key_last;
              scan_nxt = '0;
              if (k_is_let && !used_eff[k_idx] && fill_eff < ALPHA_N) begin
                inv_req.rd_en   = 1'b1;
                inv_req.rd_addr = k_idx;
                sub_req.rd_en   = 1'b1;
                sub_req.rd_addr = fill_eff;
                let_nxt         = k_idx;
                pos_nxt         = fill_eff;
                used_nxt        = used_eff | (kwsc_pkg::ALPHA'(1) << k_idx);
                fill_nxt        = fill_eff + 1'b1;
                state_nxt       = ST_WR1;
              end else if (in_key_last) begin
                state_nxt = ST_FILL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WR1: begin
        sub_req.wr_en   = 1'b1;
        sub_req.wr_addr = inv_rd;
        sub_req.wr_data = sub_rd;
        inv_req.wr_en   = 1'b1;
        inv_req.wr_addr = sub_rd;
        inv_req.wr_data = inv_rd;
        state_nxt       = ST_WR2;
      end
      ST_WR2: begin
        sub_req.wr_en   = 1'b1;
        sub_req.wr_addr = pos_r;
        sub_req.wr_data = let_r;
        inv_req.wr_en   = 1'b1;
        inv_req.wr_addr = let_r;
        inv_req.wr_data = pos_r;
        state_nxt       = last_r ? ST_FILL : ST_IDLE;
      end
      ST_FILL: begin
        if (scan_r >= ALPHA_N) begin
          kl_nxt    = 1'b0;
          last_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          scan_nxt = scan_r + 1'b1;
          if (!used_r[scan_r] && fill_r < ALPHA_N) begin
            inv_req.rd_en   = 1'b1;
            inv_req.rd_addr = scan_r;
            sub_req.rd_en   = 1'b1;
            sub_req.rd_addr = fill_r;
            let_nxt         = scan_r;
            pos_nxt         = fill_r;
            used_nxt        = used_r | (kwsc_pkg::ALPHA'(1) << scan_r);
            fill_nxt        = fill_r + 1'b1;
            state_nxt       = ST_WR1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      kl_r        <= 1'b0;
      used_r      <= '0;
      fill_r      <= '0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      kl_r        <= kl_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_dec_r  <= pend_dec_nxt;
    pend_hit_r  <= pend_hit_nxt;
    pend_byte_r <= pend_byte_nxt;
    out_byte_r  <= out_byte_nxt;
    scan_r      <= scan_nxt;
    let_r       <= let_nxt;
    pos_r       <= pos_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

endmodule

FILE: src/kwsc_chk.sv
module kwsc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_op,
  input logic [7:0] in_data_byte,
  input logic       in_key_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte
);

  // A stalled result stays presented and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("result changed or vanished while stalled");

  // Leaving reset, the block holds no result and takes input at once.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // A final key byte starts the table fill, which holds off input.
  a_fill_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == kwsc_pkg::OP_KEY && in_key_last
    |=> !in_ready ##1 !in_ready)
    else $error("input taken during table fill");

  // Key bytes give no result, so a key transfer with no cipher byte in flight
  // leaves the output empty.
  a_key_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == kwsc_pkg::OP_KEY && !out_valid &&
    !$past(in_valid && in_ready &&
           (in_op == kwsc_pkg::OP_ENC || in_op == kwsc_pkg::OP_DEC))
    |=> !out_valid ##1 !out_valid)
    else $error("result appeared for a key byte");

endmodule

bind keyword_substitution_cipher_core kwsc_chk u_kwsc_chk (.*);

FILE: verif/kwsc_checker.sv
`timescale 1ns / 100ps

// Watches both channels, keeps its own copy of the substitution tables and
// compares every output transfer with the oldest byte still owed.
module kwsc_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_data_byte,
  input  logic       in_key_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  output int         fail_count,
  output int         pending
);

  kwsc_pkg::idx_t             fwd_map [kwsc_pkg::ALPHA];
  kwsc_pkg::idx_t             rev_map [kwsc_pkg::ALPHA];
  logic [kwsc_pkg::ALPHA-1:0] placed;
  kwsc_pkg::idx_t             next_slot;
  logic                       key_open;
  logic [7:0]                 owed_bytes [$];

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    if (c >= kwsc_pkg::LOWER_A && c < kwsc_pkg::LOWER_A + kwsc_pkg::ALPHA) begin
      return c - (kwsc_pkg::LOWER_A - kwsc_pkg::UPPER_A);
    end
    return c;
  endfunction

  function automatic void clear_tables();
    int i;
    for (i = 0; i < kwsc_pkg::ALPHA; i++) begin
      fwd_map[i] = kwsc_pkg::idx_t'(i);
      rev_map[i] = kwsc_pkg::idx_t'(i);
    end
    placed    = '0;
    next_slot = '0;
    key_open  = 1'b0;
  endfunction

  // The letter swaps places with whatever held the next slot, so both maps
  // remain a permutation of the alphabet.
  function automatic void place_letter(input kwsc_pkg::idx_t letter);
    kwsc_pkg::idx_t held_at;
    kwsc_pkg::idx_t displaced;
    if (next_slot >= kwsc_pkg::ALPHA) begin
      return;
    end
    held_at            = rev_map[letter];
    displaced          = fwd_map[next_slot];
    fwd_map[held_at]   = displaced;
    rev_map[displaced] = held_at;
    fwd_map[next_slot] = letter;
    rev_map[letter]    = next_slot;
    placed[letter]     = 1'b1;
    next_slot          = next_slot + 1'b1;
  endfunction

  function automatic void apply_transfer(input logic [1:0] op, input logic [7:0] b,
                                         input logic last);
    logic [7:0] c;
    logic [7:0] r;
    int         i;
    c = fold_upper(b);
    r = b;
    case (op)
      kwsc_pkg::OP_KEY: begin
        if (!key_open) begin
          placed    = '0;
          next_slot = '0;
          key_open  = 1'b1;
        end
        if (c >= kwsc_pkg::UPPER_A && c < kwsc_pkg::UPPER_A + kwsc_pkg::ALPHA &&
            !placed[c - kwsc_pkg::UPPER_A]) begin
          place_letter(kwsc_pkg::idx_t'(c - kwsc_pkg::UPPER_A));
        end
        if (last) begin
          for (i = 0; i < kwsc_pkg::ALPHA; i++) begin
            if (!placed[i]) begin
              place_letter(kwsc_pkg::idx_t'(i));
            end
          end
          key_open = 1'b0;
        end
      end
      kwsc_pkg::OP_ENC: begin
        if (c >= kwsc_pkg::UPPER_A && c < kwsc_pkg::UPPER_A + kwsc_pkg::ALPHA) begin
          r = kwsc_pkg::UPPER_A + fwd_map[c - kwsc_pkg::UPPER_A];
        end
        owed_bytes.push_back(r);
      end
      kwsc_pkg::OP_DEC: begin
        if (b >= kwsc_pkg::UPPER_A && b < kwsc_pkg::UPPER_A + kwsc_pkg::ALPHA) begin
          r = kwsc_pkg::LOWER_A + rev_map[b - kwsc_pkg::UPPER_A];
        end
        owed_bytes.push_back(r);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void report_failure(input string what);
    if (fail_count < 10) begin
      $display("%0t: %s", $realtime, what);
    end
    fail_count++;
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      clear_tables();
      owed_bytes.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_bytes.size() == 0) begin
          report_failure($sformatf("output byte %02h with no transfer owed", out_byte));
        end else begin
          want = owed_bytes.pop_front();
          if (want !== out_byte) begin
            report_failure($sformatf("output byte %02h, expected %02h", out_byte, want));
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_transfer(in_op, in_data_byte, in_key_last);
      end
    end
    pending <= owed_bytes.size();
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         QUIET_LIMIT = 2000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_op;
  logic [7:0] in_data_byte;
  logic       in_key_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;

  int send_idle;
  int recv_idle;
  int pending;
  int fail_count;
  int quiet_cycles;

  keyword_substitution_cipher_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .in_key_last  (in_key_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte)
  );

  kwsc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .in_key_last  (in_key_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_data_byte <= b;
    in_key_last  <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [7:0] pick_text_byte();
    logic [7:0] b;
    if ($urandom_range(9) < 7) begin
      b = kwsc_pkg::UPPER_A + 8'($urandom_range(kwsc_pkg::ALPHA - 1));
      if ($urandom_range(1)) begin
        b = b + (kwsc_pkg::LOWER_A - kwsc_pkg::UPPER_A);
      end
    end else begin
      b = 8'($urandom_range(255));
    end
    return b;
  endfunction

  task automatic send_cipher_byte();
    send_item($urandom_range(1) ? kwsc_pkg::OP_ENC : kwsc_pkg::OP_DEC, pick_text_byte(),
              1'($urandom_range(1)));
  endtask

  // Long keys walk the alphabet with a stride prime to 26, so the table fills
  // completely by the closing byte at the latest. Now and then the closing flag is
  // withheld and the next key run carries on the same key.
  task automatic send_key_run(output int count);
    int         len;
    int         j;
    int         base;
    int         stride;
    logic       long_key;
    logic [7:0] b;
    long_key = ($urandom_range(9) == 0);
    len      = long_key ? $urandom_range(26, 32) : $urandom_range(1, 8);
    base     = $urandom_range(kwsc_pkg::ALPHA - 1);
    stride   = 2 * $urandom_range(3) + 1;
    count    = len;
    for (j = 0; j < len; j++) begin
      if (j > 0 && $urandom_range(9) == 0) begin
        send_cipher_byte();
        count++;
      end
      if (long_key) begin
        b = kwsc_pkg::UPPER_A + 8'((base + j * stride) % kwsc_pkg::ALPHA);
        if ($urandom_range(1)) begin
          b = b + (kwsc_pkg::LOWER_A - kwsc_pkg::UPPER_A);
        end
      end else begin
        b = pick_text_byte();
      end
      send_item(kwsc_pkg::OP_KEY, b, (j == len - 1) && ($urandom_range(9) != 0));
    end
  endtask

  task automatic run_random(input int target);
    int sent;
    int count;
    int sel;
    sent = 0;
    while (sent < target) begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        send_key_run(count);
        sent += count;
      end else if (sel < 15) begin
        send_item(OP_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        send_cipher_byte();
        sent++;
      end
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_op        = kwsc_pkg::OP_KEY;
    in_data_byte = 8'h00;
    in_key_last  = 1'b0;
    out_ready    = 1'b0;
    send_idle    = 37;
    recv_idle    = 84;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_item(kwsc_pkg::OP_ENC, "A", 1'b0);
    send_item(kwsc_pkg::OP_ENC, "z", 1'b0);
    send_item(kwsc_pkg::OP_ENC, 8'h40, 1'b0);
    send_item(kwsc_pkg::OP_ENC, 8'h7B, 1'b0);
    send_item(kwsc_pkg::OP_ENC, 8'hFF, 1'b1);
    send_item(kwsc_pkg::OP_DEC, "Z", 1'b0);
    send_item(kwsc_pkg::OP_DEC, "a", 1'b0);
    send_item(kwsc_pkg::OP_DEC, 8'h00, 1'b0);
    send_item(OP_UNUSED, 8'hAA, 1'b1);
    send_item(kwsc_pkg::OP_KEY, "z", 1'b0);
    send_item(kwsc_pkg::OP_KEY, "E", 1'b0);
    send_item(kwsc_pkg::OP_KEY, "b", 1'b0);
    send_item(kwsc_pkg::OP_KEY, "z", 1'b0);
    send_item(kwsc_pkg::OP_KEY, "7", 1'b0);
    send_item(kwsc_pkg::OP_ENC, "E", 1'b0);
    send_item(kwsc_pkg::OP_DEC, "B", 1'b0);
    send_item(kwsc_pkg::OP_KEY, 8'h60, 1'b1);
    send_item(kwsc_pkg::OP_ENC, "a", 1'b0);
    send_item(kwsc_pkg::OP_ENC, "Z", 1'b0);
    send_item(kwsc_pkg::OP_DEC, "Z", 1'b0);
    send_item(kwsc_pkg::OP_DEC, "A", 1'b0);
    send_item(kwsc_pkg::OP_KEY, "Q", 1'b1);
    send_item(kwsc_pkg::OP_ENC, "q", 1'b0);
    send_item(kwsc_pkg::OP_DEC, 8'h5B, 1'b0);
    send_item(kwsc_pkg::OP_ENC, 8'h80, 1'b0);

    run_random(140);
    drain_results();
    send_idle = 84;
    recv_idle = 37;
    run_random(140);
    drain_results();
    send_idle = 0;
    recv_idle = 0;
    run_random(140);
    drain_results();
    repeat (100) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
